// ===== rtl/c8_pkg.sv =====
// Shared types, constants and helper functions of the CHIP-8 execute unit.
package c8_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int FRAME_BYTES = 256;
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int PC_W        = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [PC_W-1:0] START_ADDR_RST = 13'd512;
  localparam logic [15:0]     SEED_RST       = 16'd44257;
  localparam logic [15:0]     LFSR_TAPS      = 16'hB400;
  localparam int              FONT_BYTES     = 80;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_HALTED    = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED   = 1'd1;

  // instruction groups (high nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDIX = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [7:0] LO_CLS  = 8'hE0;
  localparam logic [7:0] LO_RET  = 8'hEE;
  localparam logic [7:0] LO_SKP  = 8'h9E;
  localparam logic [7:0] LO_SKNP = 8'hA1;
  localparam logic [7:0] LO_GDT  = 8'h07;
  localparam logic [7:0] LO_WKEY = 8'h0A;
  localparam logic [7:0] LO_SDT  = 8'h15;
  localparam logic [7:0] LO_SST  = 8'h18;
  localparam logic [7:0] LO_ADDX = 8'h1E;
  localparam logic [7:0] LO_FONT = 8'h29;
  localparam logic [7:0] LO_BCD  = 8'h33;
  localparam logic [7:0] LO_STR  = 8'h55;
  localparam logic [7:0] LO_LDR  = 8'h65;

  // 8xyN operations
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [3:0] FLAG_REG = 4'hF;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       wr_x;
    logic       wr_f;
  } alu_res_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_RDFB, S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_EXEC,
    S_WRF, S_RET, S_CLR, S_DMEM, S_DROW, S_DW1, S_DW2, S_BCD,
    S_STR_RD, S_STR_WR, S_LDR_RD, S_LDR_WR, S_FIN
  } state_t;

  function automatic logic [7:0] font_byte(logic [MEM_AW-1:0] a);
    logic [7:0] b;
    b = 8'h00;
    if (a < MEM_AW'(FONT_BYTES)) b = FONT[a[6:0]];
    return b;
  endfunction

  // decimal digit k (0 hundreds, 1 tens, 2 ones) of v
  function automatic logic [7:0] bcd_digit(logic [7:0] v, logic [1:0] k);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [6:0]  u;
    logic [7:0]  d;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    prod = {8'b0, r[6:0]} * 15'd205;   // r/10 for r below 100
    t = prod[14:11];
    u = r[6:0] - ({t, 3'b0} + {2'b0, t, 1'b0});
    case (k)
      2'd0:    d = {6'b0, h};
      2'd1:    d = {4'b0, t};
      default: d = {1'b0, u};
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/c8_if.sv =====
// Request, result and configuration channels of the CHIP-8 execute unit.
interface c8_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [c8_pkg::MEM_AW-1:0]   address;
  logic [7:0]                  data;
  logic [15:0]                 keys;
  modport source(output valid, cmd, address, data, keys, input ready);
  modport sink(input valid, cmd, address, data, keys, output ready);
endinterface

interface c8_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [7:0]                read_data;
  logic [c8_pkg::PC_W-1:0]   pc_now;
  logic                      display_changed;
  logic                      sound_on;
  modport source(output valid, status, read_data, pc_now, display_changed, sound_on,
                 input ready);
  modport sink(input valid, status, read_data, pc_now, display_changed, sound_on,
               output ready);
endinterface

interface c8_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [c8_pkg::CFG_IDX_W-1:0]    index;
  logic [c8_pkg::CFG_DATA_W-1:0]   value;
  modport source(output valid, index, value, input ready);
  modport sink(input valid, index, value, output ready);
endinterface

// ===== rtl/c8_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/c8_alu.sv =====
// Register-register ALU for the 8xyN instruction group.
module c8_alu (
  input  logic [3:0]       n,
  input  logic [7:0]       a,
  input  logic [7:0]       b,
  output c8_pkg::alu_res_t r
);

  logic [8:0] sum;
  logic [8:0] dif;
  logic [8:0] difn;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign dif  = {1'b0, a} - {1'b0, b};
  assign difn = {1'b0, b} - {1'b0, a};

  always_comb begin
    r = '0;
    unique case (n)
      c8_pkg::ALU_MOV: begin
        r.res  = b;
        r.wr_x = 1'b1;
      end
      c8_pkg::ALU_OR: begin
        r.res  = a | b;
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      c8_pkg::ALU_AND: begin
        r.res  = a & b;
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      c8_pkg::ALU_XOR: begin
        r.res  = a ^ b;
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      c8_pkg::ALU_ADD: begin
        r.res  = sum[7:0];
        r.flag = sum[8];
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      c8_pkg::ALU_SUB: begin
        r.res  = dif[7:0];
        r.flag = ~dif[8];
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      c8_pkg::ALU_SHR: begin
        r.res  = {1'b0, b[7:1]};
        r.flag = b[0];
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      c8_pkg::ALU_SUBN: begin
        r.res  = difn[7:0];
        r.flag = ~difn[8];
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      c8_pkg::ALU_SHL: begin
        r.res  = {b[6:0], 1'b0};
        r.flag = b[7];
        r.wr_x = 1'b1;
        r.wr_f = 1'b1;
      end
      default: r = '0;
    endcase
  end

endmodule

// ===== rtl/chip8_core_execute_unit.sv =====
// CHIP-8 execute unit: memory, frame buffer, registers, stack, timers and sequencer.
//
// One request is handled at a time by a small sequencer around memories with
// one write port and one read port (4 KiB main memory, 256-byte frame buffer,
// 16-entry register file, return stack), so the memory ports set the timing.
// After reset the unit loads the font and clears memory, frame buffer and
// registers; no request is taken then, configuration writes are. A plain
// instruction fetches 2 bytes, reads VX, VY and V0, and executes; a draw
// works sprite row by row, Fx55/Fx65 register by register, a clear entry by
// entry. The result sits in an output register until taken.
module chip8_core_execute_unit (
  input logic       clk,
  input logic       rst,
  c8_req_if.sink    req,
  c8_res_if.source  res,
  c8_cfg_if.sink    cfg
);

  c8_pkg::state_t  state, state_next;
  logic [c8_pkg::MEM_AW-1:0] cnt, cnt_next;

  c8_pkg::cmd_t    cmd_q, cmd_q_next;
  logic [c8_pkg::MEM_AW-1:0] addr_q, addr_q_next;
  logic [15:0]     keys_q, keys_q_next;
  logic [7:0]      hi, hi_next, lo, lo_next;
  logic [7:0]      vx, vx_next, vy, vy_next, v0, v0_next;
  logic [7:0]      sbyte, sbyte_next;
  logic            coll, coll_next;
  logic            flag_q, flag_q_next;
  logic [7:0]      rd_q, rd_q_next;
  c8_pkg::status_t status_q, status_q_next;

  logic [c8_pkg::PC_W-1:0] pc, pc_next;
  logic [15:0]     idx, idx_next;
  logic [c8_pkg::SP_W-1:0] sp, sp_next;
  logic [7:0]      dt, dt_next, st, st_next;
  logic            waiting, waiting_next;
  logic [15:0]     last_keys, last_keys_next;
  logic            dirty, dirty_next;
  logic [15:0]     lfsr, lfsr_next;

  logic            res_valid, res_valid_next;
  c8_pkg::status_t res_status, res_status_next;
  logic [7:0]      res_rd, res_rd_next;
  logic [c8_pkg::PC_W-1:0] res_pc, res_pc_next;
  logic            res_dirty, res_dirty_next;
  logic            res_snd, res_snd_next;

  // memory ports
  logic                       mem_we;
  logic [c8_pkg::MEM_AW-1:0]  mem_waddr, mem_raddr;
  logic [7:0]                 mem_wdata, mem_rd;
  logic                       fb_we;
  logic [c8_pkg::FB_AW-1:0]   fb_waddr, fb_raddr;
  logic [7:0]                 fb_wdata, fb_rd;
  logic                       reg_we;
  logic [3:0]                 reg_waddr, reg_raddr;
  logic [7:0]                 reg_wdata, reg_rd;
  logic                       stk_we;
  logic [c8_pkg::STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [c8_pkg::MEM_AW-1:0]  stk_wdata, stk_rd;

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MEM_BYTES)) u_mem (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
    .rd_addr(mem_raddr), .rd_data(mem_rd));
  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::FRAME_BYTES)) u_fb (
    .clk(clk), .wr_en(fb_we), .wr_addr(fb_waddr), .wr_data(fb_wdata),
    .rd_addr(fb_raddr), .rd_data(fb_rd));
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .wr_en(reg_we), .wr_addr(reg_waddr), .wr_data(reg_wdata),
    .rd_addr(reg_raddr), .rd_data(reg_rd));
  c8_ram #(.WIDTH(c8_pkg::MEM_AW), .DEPTH(c8_pkg::STACK_DEPTH)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
    .rd_addr(stk_raddr), .rd_data(stk_rd));

  // instruction fields
  logic [3:0]  op, x, y, n;
  logic [c8_pkg::MEM_AW-1:0] nnn;
  logic [c8_pkg::PC_W-1:0]   pc2, pc4;
  c8_pkg::alu_res_t alu;
  logic [c8_pkg::SP_W-1:0]   sp_dec;
  logic [15:0] lfsr_step;
  logic [15:0] rel;
  logic        rel_any;
  logic [3:0]  rel_idx;
  logic [2:0]  sh, sh_inv, col;
  logic [4:0]  row;
  logic [7:0]  p1, p2;
  logic [c8_pkg::FB_AW-1:0] pos1, pos2;

  assign op  = hi[7:4];
  assign x   = hi[3:0];
  assign y   = lo[7:4];
  assign n   = lo[3:0];
  assign nnn = {hi[3:0], lo};
  assign pc2 = pc + c8_pkg::PC_W'(2);
  assign pc4 = pc + c8_pkg::PC_W'(4);
  assign sp_dec = sp - c8_pkg::SP_W'(1);
  assign lfsr_step = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? c8_pkg::LFSR_TAPS : 16'h0000);

  c8_alu u_alu (.n(n), .a(vx), .b(vy), .r(alu));

  // lowest key held at the previous execute and released now
  assign rel = last_keys & ~keys_q;
  always_comb begin
    rel_idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (rel[i]) rel_idx = 4'(i);
    end
  end
  assign rel_any = |rel;

  // sprite placement; a byte straddling the row end wraps within its row
  assign sh     = vx[2:0];
  assign sh_inv = 3'd0 - sh;
  assign col    = vx[5:3];
  assign row    = vy[4:0] + {1'b0, cnt[3:0]};
  assign pos1   = {row, col};
  assign pos2   = {row, 3'(col + 3'd1)};
  assign p1     = sbyte >> sh;
  assign p2     = sbyte << sh_inv;

  assign req.ready           = (state == c8_pkg::S_IDLE);
  assign cfg.ready           = 1'b1;
  assign res.valid           = res_valid;
  assign res.status          = res_status;
  assign res.read_data       = res_rd;
  assign res.pc_now          = res_pc;
  assign res.display_changed = res_dirty;
  assign res.sound_on        = res_snd;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cmd_q_next      = cmd_q;
    addr_q_next     = addr_q;
    keys_q_next     = keys_q;
    hi_next         = hi;
    lo_next         = lo;
    vx_next         = vx;
    vy_next         = vy;
    v0_next         = v0;
    sbyte_next      = sbyte;
    coll_next       = coll;
    flag_q_next     = flag_q;
    rd_q_next       = rd_q;
    status_q_next   = status_q;
    pc_next         = pc;
    idx_next        = idx;
    sp_next         = sp;
    dt_next         = dt;
    st_next         = st;
    waiting_next    = waiting;
    last_keys_next  = last_keys;
    dirty_next      = dirty;
    lfsr_next       = lfsr;
    res_valid_next  = res_valid & ~res.ready;
    res_status_next = res_status;
    res_rd_next     = res_rd;
    res_pc_next     = res_pc;
    res_dirty_next  = res_dirty;
    res_snd_next    = res_snd;

    mem_we    = 1'b0;
    mem_waddr = idx[c8_pkg::MEM_AW-1:0];
    mem_wdata = 8'h00;
    mem_raddr = pc[c8_pkg::MEM_AW-1:0];
    fb_we     = 1'b0;
    fb_waddr  = pos1;
    fb_wdata  = 8'h00;
    fb_raddr  = pos1;
    reg_we    = 1'b0;
    reg_waddr = x;
    reg_wdata = 8'h00;
    reg_raddr = x;
    stk_we    = 1'b0;
    stk_waddr = sp[c8_pkg::STK_AW-1:0];
    stk_wdata = pc[c8_pkg::MEM_AW-1:0];
    stk_raddr = sp_dec[c8_pkg::STK_AW-1:0];

    unique case (state)
      c8_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt;
        mem_wdata = c8_pkg::font_byte(cnt);
        fb_we     = 1'b1;
        fb_waddr  = cnt[c8_pkg::FB_AW-1:0];
        reg_we    = 1'b1;
        reg_waddr = cnt[3:0];
        cnt_next  = cnt + c8_pkg::MEM_AW'(1);
        if (&cnt) state_next = c8_pkg::S_IDLE;
      end

      c8_pkg::S_IDLE: begin
        fb_raddr = req.address[c8_pkg::FB_AW-1:0];
        if (req.valid) begin
          cmd_q_next    = c8_pkg::cmd_t'(req.cmd);
          addr_q_next   = req.address;
          keys_q_next   = req.keys;
          rd_q_next     = 8'h00;
          status_q_next = c8_pkg::ST_OK;
          case (c8_pkg::cmd_t'(req.cmd))
            c8_pkg::CMD_WRITE: begin
              mem_we     = 1'b1;
              mem_waddr  = req.address;
              mem_wdata  = req.data;
              state_next = c8_pkg::S_FIN;
            end
            c8_pkg::CMD_EXEC: state_next = c8_pkg::S_F1;
            c8_pkg::CMD_READ: state_next = c8_pkg::S_RDFB;
            default:          state_next = c8_pkg::S_FIN;
          endcase
        end
      end

      c8_pkg::S_RDFB: begin
        if (addr_q[c8_pkg::MEM_AW-1:c8_pkg::FB_AW] == '0) rd_q_next = fb_rd;
        state_next = c8_pkg::S_FIN;
      end

      c8_pkg::S_F1: begin
        if (pc >= c8_pkg::PC_W'(c8_pkg::MEM_BYTES)) begin
          status_q_next = c8_pkg::ST_HALTED;
          state_next    = c8_pkg::S_FIN;
        end else begin
          state_next = c8_pkg::S_F2;
        end
      end

      c8_pkg::S_F2: begin
        hi_next    = mem_rd;
        mem_raddr  = pc[c8_pkg::MEM_AW-1:0] + c8_pkg::MEM_AW'(1);
        state_next = c8_pkg::S_F3;
      end

      c8_pkg::S_F3: begin
        lo_next    = mem_rd;
        reg_raddr  = x;
        state_next = c8_pkg::S_F4;
      end

      c8_pkg::S_F4: begin
        vx_next    = reg_rd;
        reg_raddr  = y;
        state_next = c8_pkg::S_F5;
      end

      c8_pkg::S_F5: begin
        vy_next    = reg_rd;
        reg_raddr  = 4'd0;
        state_next = c8_pkg::S_F6;
      end

      c8_pkg::S_F6: begin
        v0_next    = reg_rd;
        state_next = c8_pkg::S_EXEC;
      end

      c8_pkg::S_EXEC: begin
        pc_next    = pc2;
        state_next = c8_pkg::S_FIN;
        cnt_next   = '0;
        case (op)
          c8_pkg::OP_SYS: begin
            if (lo == c8_pkg::LO_CLS) begin
              state_next = c8_pkg::S_CLR;
            end else if (lo == c8_pkg::LO_RET) begin
              if (sp == '0) begin
                status_q_next = c8_pkg::ST_UNDERFLOW;
              end else begin
                sp_next    = sp_dec;
                state_next = c8_pkg::S_RET;
              end
            end
          end
          c8_pkg::OP_JP: pc_next = {1'b0, nnn};
          c8_pkg::OP_CALL: begin
            if (sp >= c8_pkg::SP_W'(c8_pkg::STACK_DEPTH)) begin
              status_q_next = c8_pkg::ST_OVERFLOW;
            end else begin
              stk_we  = 1'b1;
              sp_next = sp + c8_pkg::SP_W'(1);
              pc_next = {1'b0, nnn};
            end
          end
          c8_pkg::OP_SEI:  if (vx == lo) pc_next = pc4;
          c8_pkg::OP_SNEI: if (vx != lo) pc_next = pc4;
          c8_pkg::OP_SER:  if (vx == vy) pc_next = pc4;
          c8_pkg::OP_SNER: if (n == 4'd0 && vx != vy) pc_next = pc4;
          c8_pkg::OP_LDI: begin
            reg_we    = 1'b1;
            reg_wdata = lo;
          end
          c8_pkg::OP_ADDI: begin
            reg_we    = 1'b1;
            reg_wdata = vx + lo;
          end
          c8_pkg::OP_ALU: begin
            reg_we      = alu.wr_x;
            reg_wdata   = alu.res;
            flag_q_next = alu.flag;
            if (alu.wr_f) state_next = c8_pkg::S_WRF;
          end
          c8_pkg::OP_LDIX: idx_next = {4'b0, nnn};
          c8_pkg::OP_JPV0: pc_next = {1'b0, nnn} + {5'b0, v0};
          c8_pkg::OP_RND: begin
            lfsr_next = lfsr_step;
            reg_we    = 1'b1;
            reg_wdata = lfsr_step[7:0] & lo;
          end
          c8_pkg::OP_DRW: begin
            coll_next  = 1'b0;
            state_next = c8_pkg::S_DMEM;
          end
          c8_pkg::OP_KEY: begin
            if (lo == c8_pkg::LO_SKP && keys_q[vx[3:0]]) pc_next = pc4;
            if (lo == c8_pkg::LO_SKNP && !keys_q[vx[3:0]]) pc_next = pc4;
          end
          default: begin
            case (lo)
              c8_pkg::LO_GDT: begin
                reg_we    = 1'b1;
                reg_wdata = dt;
              end
              c8_pkg::LO_SDT:  dt_next = vx;
              c8_pkg::LO_SST:  st_next = vx;
              c8_pkg::LO_FONT: idx_next = {6'b0, vx, 2'b0} + {8'b0, vx};
              c8_pkg::LO_ADDX: idx_next = idx + {8'b0, vx};
              c8_pkg::LO_BCD:  state_next = c8_pkg::S_BCD;
              c8_pkg::LO_STR:  state_next = c8_pkg::S_STR_RD;
              c8_pkg::LO_LDR:  state_next = c8_pkg::S_LDR_RD;
              c8_pkg::LO_WKEY: begin
                pc_next = pc;
                if (!waiting) begin
                  waiting_next = 1'b1;
                end else if (rel_any) begin
                  waiting_next = 1'b0;
                  reg_we       = 1'b1;
                  reg_wdata    = {4'b0, rel_idx};
                  pc_next      = pc2;
                end
              end
              default: ;
            endcase
          end
        endcase
      end

      c8_pkg::S_WRF: begin
        reg_we     = 1'b1;
        reg_waddr  = c8_pkg::FLAG_REG;
        reg_wdata  = {7'b0, flag_q};
        state_next = c8_pkg::S_FIN;
      end

      c8_pkg::S_RET: begin
        pc_next    = {1'b0, stk_rd} + c8_pkg::PC_W'(2);
        state_next = c8_pkg::S_FIN;
      end

      // read entry cnt while zeroing entry cnt-1
      c8_pkg::S_CLR: begin
        fb_raddr = cnt[c8_pkg::FB_AW-1:0];
        fb_waddr = cnt[c8_pkg::FB_AW-1:0] - c8_pkg::FB_AW'(1);
        if (cnt != '0) begin
          fb_we = 1'b1;
          if (fb_rd != 8'h00) dirty_next = 1'b1;
        end
        cnt_next = cnt + c8_pkg::MEM_AW'(1);
        if (cnt == c8_pkg::MEM_AW'(c8_pkg::FRAME_BYTES)) state_next = c8_pkg::S_FIN;
      end

      c8_pkg::S_DMEM: begin
        mem_raddr = idx[c8_pkg::MEM_AW-1:0] + {8'b0, cnt[3:0]};
        if (cnt[3:0] == n) begin
          reg_we     = 1'b1;
          reg_waddr  = c8_pkg::FLAG_REG;
          reg_wdata  = {7'b0, coll};
          state_next = c8_pkg::S_FIN;
        end else begin
          state_next = c8_pkg::S_DROW;
        end
      end

      c8_pkg::S_DROW: begin
        sbyte_next = mem_rd;
        fb_raddr   = pos1;
        state_next = c8_pkg::S_DW1;
      end

      c8_pkg::S_DW1: begin
        fb_we    = 1'b1;
        fb_waddr = pos1;
        fb_wdata = fb_rd ^ p1;
        fb_raddr = pos2;
        if ((fb_rd & p1) != 8'h00) coll_next = 1'b1;
        if (p1 != 8'h00) dirty_next = 1'b1;
        if (sh != 3'd0) begin
          state_next = c8_pkg::S_DW2;
        end else begin
          cnt_next   = cnt + c8_pkg::MEM_AW'(1);
          state_next = c8_pkg::S_DMEM;
        end
      end

      c8_pkg::S_DW2: begin
        fb_we    = 1'b1;
        fb_waddr = pos2;
        fb_wdata = fb_rd ^ p2;
        if ((fb_rd & p2) != 8'h00) coll_next = 1'b1;
        if (p2 != 8'h00) dirty_next = 1'b1;
        cnt_next   = cnt + c8_pkg::MEM_AW'(1);
        state_next = c8_pkg::S_DMEM;
      end

      c8_pkg::S_BCD: begin
        mem_we    = 1'b1;
        mem_waddr = idx[c8_pkg::MEM_AW-1:0] + {10'b0, cnt[1:0]};
        mem_wdata = c8_pkg::bcd_digit(vx, cnt[1:0]);
        cnt_next  = cnt + c8_pkg::MEM_AW'(1);
        if (cnt[1:0] == 2'd2) state_next = c8_pkg::S_FIN;
      end

      c8_pkg::S_STR_RD: begin
        reg_raddr  = cnt[3:0];
        state_next = c8_pkg::S_STR_WR;
      end

      c8_pkg::S_STR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[c8_pkg::MEM_AW-1:0];
        mem_wdata = reg_rd;
        idx_next  = idx + 16'd1;
        cnt_next  = cnt + c8_pkg::MEM_AW'(1);
        state_next = (cnt[3:0] == x) ? c8_pkg::S_FIN : c8_pkg::S_STR_RD;
      end

      c8_pkg::S_LDR_RD: begin
        mem_raddr  = idx[c8_pkg::MEM_AW-1:0];
        state_next = c8_pkg::S_LDR_WR;
      end

      c8_pkg::S_LDR_WR: begin
        reg_we    = 1'b1;
        reg_waddr = cnt[3:0];
        reg_wdata = mem_rd;
        idx_next  = idx + 16'd1;
        cnt_next  = cnt + c8_pkg::MEM_AW'(1);
        state_next = (cnt[3:0] == x) ? c8_pkg::S_FIN : c8_pkg::S_LDR_RD;
      end

      c8_pkg::S_FIN: begin
        if (!res_valid || res.ready) begin
          res_valid_next  = 1'b1;
          res_status_next = status_q;
          res_rd_next     = rd_q;
          res_pc_next     = pc;
          res_dirty_next  = dirty;
          res_snd_next    = 1'b0;
          if (cmd_q == c8_pkg::CMD_TICK) begin
            res_snd_next = (st >= 8'd2);
            if (dt != 8'd0) dt_next = dt - 8'd1;
            if (st != 8'd0) st_next = st - 8'd1;
            dirty_next = 1'b0;
          end
          if (cmd_q == c8_pkg::CMD_EXEC && status_q != c8_pkg::ST_HALTED)
            last_keys_next = keys_q;
          state_next = c8_pkg::S_IDLE;
        end
      end

      default: state_next = c8_pkg::S_IDLE;
    endcase

    if (cfg.valid) begin
      unique case (cfg.index)
        c8_pkg::CFG_START_ADDRESS: pc_next = {1'b0, cfg.value[c8_pkg::MEM_AW-1:0]};
        c8_pkg::CFG_RANDOM_SEED:   lfsr_next = cfg.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= c8_pkg::S_INIT;
      cnt       <= '0;
      pc        <= c8_pkg::START_ADDR_RST;
      idx       <= '0;
      sp        <= '0;
      dt        <= '0;
      st        <= '0;
      waiting   <= 1'b0;
      last_keys <= '0;
      dirty     <= 1'b1;
      lfsr      <= c8_pkg::SEED_RST;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pc        <= pc_next;
      idx       <= idx_next;
      sp        <= sp_next;
      dt        <= dt_next;
      st        <= st_next;
      waiting   <= waiting_next;
      last_keys <= last_keys_next;
      dirty     <= dirty_next;
      lfsr      <= lfsr_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_q_next;
    addr_q     <= addr_q_next;
    keys_q     <= keys_q_next;
    hi         <= hi_next;
    lo         <= lo_next;
    vx         <= vx_next;
    vy         <= vy_next;
    v0         <= v0_next;
    sbyte      <= sbyte_next;
    coll       <= coll_next;
    flag_q     <= flag_q_next;
    rd_q       <= rd_q_next;
    status_q   <= status_q_next;
    res_status <= res_status_next;
    res_rd     <= res_rd_next;
    res_pc     <= res_pc_next;
    res_dirty  <= res_dirty_next;
    res_snd    <= res_snd_next;
  end

endmodule

// ===== dv/chip8_core_execute_checker.sv =====
// Checker for the CHIP-8 execute unit: follows the channels, predicts results, compares.
module chip8_core_execute_checker
  import c8_pkg::*;
(
  input  logic clk,
  input  logic rst,
  c8_req_if    req,
  c8_res_if    res,
  c8_cfg_if    cfg,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    status_t             status;
    logic [7:0]          read_data;
    logic [PC_W-1:0]     pc_now;
    logic                display_changed;
    logic                sound_on;
  } outcome_t;

  outcome_t due_q[$];

  logic [7:0]      mem [MEM_BYTES];
  logic [7:0]      fb [FRAME_BYTES];
  logic [7:0]      vreg [16];
  logic [15:0]     ireg;
  logic [PC_W-1:0] pc;
  logic [11:0]     start_pc;
  logic [11:0]     ret_stack [STACK_DEPTH];
  int              depth;
  logic [7:0]      delay_t;
  logic [7:0]      sound_t;
  logic            key_wait;
  logic [15:0]     seen_keys;
  logic            dirty;
  logic [15:0]     lfsr;

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  function automatic void clear_model();
    foreach (mem[i]) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
    foreach (fb[i]) fb[i] = 8'h00;
    foreach (vreg[i]) vreg[i] = 8'h00;
    ireg      = '0;
    start_pc  = START_ADDR_RST[11:0];
    pc        = START_ADDR_RST;
    depth     = 0;
    delay_t   = '0;
    sound_t   = '0;
    key_wait  = 1'b0;
    seen_keys = '0;
    dirty     = 1'b1;
    lfsr      = SEED_RST;
  endfunction

  function automatic void blend(int pos, logic [7:0] pat);
    logic [7:0] old;
    old = fb[pos & 255];
    if ((old & pat) != 0) vreg[FLAG_REG] = 8'd1;
    if (pat != 0) dirty = 1'b1;
    fb[pos & 255] = old ^ pat;
  endfunction

  function automatic void draw(logic [7:0] vx, logic [7:0] vy, logic [3:0] rows);
    int col, sh, row;
    logic [7:0] s, lpart, rpart;
    col = vx[5:3];
    sh  = vx[2:0];
    vreg[FLAG_REG] = 8'd0;
    for (int r = 0; r < rows; r++) begin
      row = (vy + r) & 31;
      s   = mem[(ireg + r) & 16'h0FFF];
      if (sh == 0) begin
        blend(row * 8 + col, s);
      end else begin
        lpart = s >> sh;
        rpart = s << (8 - sh);
        blend(row * 8 + col, lpart);
        blend(row * 8 + ((col + 1) & 7), rpart);  // wraps within the row
      end
    end
  endfunction

  function automatic void alu(logic [3:0] x, logic [3:0] y, logic [3:0] n);
    logic [7:0] a, b, f;
    logic [8:0] sum;
    a = vreg[x];
    b = vreg[y];
    case (n)
      ALU_MOV: vreg[x] = b;
      ALU_OR:  begin vreg[x] = a | b; vreg[FLAG_REG] = 0; end
      ALU_AND: begin vreg[x] = a & b; vreg[FLAG_REG] = 0; end
      ALU_XOR: begin vreg[x] = a ^ b; vreg[FLAG_REG] = 0; end
      ALU_ADD: begin
        sum = a + b;
        vreg[x] = sum[7:0];
        vreg[FLAG_REG] = {7'b0, sum[8]};
      end
      ALU_SUB: begin
        f = (a >= b);
        vreg[x] = a - b;
        vreg[FLAG_REG] = f;
      end
      ALU_SHR: begin
        f = {7'b0, b[0]};
        vreg[x] = b >> 1;
        vreg[FLAG_REG] = f;
      end
      ALU_SUBN: begin
        f = (b >= a);
        vreg[x] = b - a;
        vreg[FLAG_REG] = f;
      end
      ALU_SHL: begin
        f = {7'b0, b[7]};
        vreg[x] = b << 1;
        vreg[FLAG_REG] = f;
      end
      default: ;
    endcase
  endfunction

  function automatic status_t run_instr(logic [15:0] keys, output bit jumped);
    logic [7:0]  hi, lo, val;
    logic [3:0]  op, x, y, n;
    logic [11:0] nnn;
    bit          skip;
    logic        k;
    hi  = mem[pc[11:0]];
    lo  = mem[pc[11:0] + 12'd1];   // wraps to 0 at the last byte
    op  = hi[7:4];
    x   = hi[3:0];
    y   = lo[7:4];
    n   = lo[3:0];
    nnn = {hi[3:0], lo};
    skip = 0;
    jumped = 0;
    case (op)
      OP_SYS: begin
        if (lo == LO_CLS) begin
          foreach (fb[i]) begin
            if (fb[i] != 0) dirty = 1'b1;
            fb[i] = 8'h00;
          end
        end else if (lo == LO_RET) begin
          if (depth == 0) return ST_UNDERFLOW;
          depth--;
          pc = {1'b0, ret_stack[depth]} + 13'd2;
          jumped = 1;
        end
      end
      OP_JP: begin pc = {1'b0, nnn}; jumped = 1; end
      OP_CALL: begin
        if (depth >= STACK_DEPTH) return ST_OVERFLOW;
        ret_stack[depth] = pc[11:0];
        depth++;
        pc = {1'b0, nnn};
        jumped = 1;
      end
      OP_SEI:  skip = vreg[x] == lo;
      OP_SNEI: skip = vreg[x] != lo;
      OP_SER:  skip = vreg[x] == vreg[y];
      OP_LDI:  vreg[x] = lo;
      OP_ADDI: vreg[x] = vreg[x] + lo;
      OP_ALU:  alu(x, y, n);
      OP_SNER: skip = (n == 0) && (vreg[x] != vreg[y]);
      OP_LDIX: ireg = {4'b0, nnn};
      OP_JPV0: begin pc = {1'b0, nnn} + {5'b0, vreg[0]}; jumped = 1; end
      OP_RND: begin
        k = lfsr[0];
        lfsr = lfsr >> 1;
        if (k) lfsr = lfsr ^ LFSR_TAPS;
        vreg[x] = lfsr[7:0] & lo;
      end
      OP_DRW: draw(vreg[x], vreg[y], n);
      OP_KEY: begin
        k = keys[vreg[x][3:0]];
        if (lo == LO_SKP) skip = k;
        else if (lo == LO_SKNP) skip = !k;
      end
      default: begin
        val = vreg[x];
        case (lo)
          LO_GDT:  vreg[x] = delay_t;
          LO_SDT:  delay_t = val;
          LO_SST:  sound_t = val;
          LO_FONT: ireg = val * 5;
          LO_BCD: begin
            mem[ireg[11:0]]         = val / 100;
            mem[ireg[11:0] + 12'd1] = (val / 10) % 10;
            mem[ireg[11:0] + 12'd2] = val % 10;
          end
          LO_STR:
            for (int i = 0; i <= x; i++) begin
              mem[ireg[11:0]] = vreg[i];
              ireg++;
            end
          LO_LDR:
            for (int i = 0; i <= x; i++) begin
              vreg[i] = mem[ireg[11:0]];
              ireg++;
            end
          LO_WKEY: begin
            // pc holds until a key pressed last time is released now
            jumped = 1;
            if (!key_wait) begin
              key_wait = 1'b1;
            end else begin
              for (int i = 0; i < 16; i++) begin
                if (seen_keys[i] && !keys[i]) begin
                  key_wait = 1'b0;
                  vreg[x] = i;
                  jumped = 0;
                  break;
                end
              end
            end
          end
          LO_ADDX: ireg = ireg + val;
          default: ;
        endcase
      end
    endcase
    if (skip) begin
      pc = pc + 13'd4;
      jumped = 1;
    end
    return ST_OK;
  endfunction

  function automatic outcome_t predict(cmd_t c, logic [11:0] a, logic [7:0] d,
                                       logic [15:0] keys);
    outcome_t o;
    bit       jumped;
    o = '0;
    o.status = ST_OK;
    case (c)
      CMD_WRITE: mem[a] = d;
      CMD_EXEC: begin
        if (pc >= MEM_BYTES) begin
          o.status = ST_HALTED;
        end else begin
          o.status = run_instr(keys, jumped);
          if (!jumped) pc = pc + 13'd2;
          seen_keys = keys;
        end
      end
      CMD_READ: if (a < FRAME_BYTES) o.read_data = fb[a];
      default: ;
    endcase
    o.display_changed = dirty;
    if (c == CMD_TICK) begin
      o.sound_on = sound_t >= 2;
      if (delay_t != 0) delay_t--;
      if (sound_t != 0) sound_t--;
      dirty = 1'b0;
    end
    o.pc_now = pc;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      clear_model();
      due_q.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_START_ADDRESS) begin
          start_pc = cfg.value[11:0];
          pc = {1'b0, start_pc};
        end else begin
          lfsr = cfg.value;
        end
      end
      if (req.valid && req.ready)
        due_q.push_back(predict(cmd_t'(req.cmd), req.address, req.data, req.keys));
      if (res.valid && res.ready) begin
        if (due_q.size() == 0) begin
          report("unexpected result pc", res.pc_now, 0);
        end else begin
          want = due_q.pop_front();
          if (res.status != want.status) report("status", res.status, want.status);
          if (res.read_data != want.read_data)
            report("read_data", res.read_data, want.read_data);
          if (res.pc_now != want.pc_now) report("pc_now", res.pc_now, want.pc_now);
          if (res.display_changed != want.display_changed)
            report("display_changed", res.display_changed, want.display_changed);
          if (res.sound_on != want.sound_on)
            report("sound_on", res.sound_on, want.sound_on);
        end
      end
    end
    pending = due_q.size();
  end

endmodule

// ===== dv/chip8_core_execute_unit_test.sv =====
// Testbench top for the CHIP-8 execute unit: stimulus, reset, clock and verdict.
module chip8_core_execute_unit_test;
  import c8_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PROG_WORDS  = 48;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   awaiting;
  int   cycles = 0;
  bit   calm = 0;
  bit   long_hold = 0;
  logic [15:0] held_keys = '0;

  c8_req_if req_ch();
  c8_res_if res_ch();
  c8_cfg_if cfg_ch();

  chip8_core_execute_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  chip8_core_execute_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .errors  (mismatches),
    .pending (awaiting)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    req_ch.valid   = 1'b0;
    req_ch.cmd     = CMD_WRITE;
    req_ch.address = '0;
    req_ch.data    = '0;
    req_ch.keys    = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_START_ADDRESS;
    cfg_ch.value   = '0;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 0;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic push_req(cmd_t c, logic [11:0] a, logic [7:0] d, logic [15:0] k);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= c;
    req_ch.address <= a;
    req_ch.data    <= d;
    req_ch.keys    <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // wait until every request has its result
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  task automatic set_config(logic [11:0] start, logic [15:0] seed);
    write_reg(CFG_START_ADDRESS, {4'($urandom), start});
    write_reg(CFG_RANDOM_SEED, seed);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_word(logic [11:0] a, logic [15:0] w);
    push_req(CMD_WRITE, a, w[15:8], 16'($urandom));
    push_req(CMD_WRITE, a + 12'd1, w[7:0], 16'($urandom));
  endtask

  function automatic logic [15:0] make_instr(logic [11:0] base, int idx);
    logic [11:0] dest;
    logic [3:0]  op, x, y;
    logic [7:0]  lo;
    int          pick;
    dest = base + 12'(2 * $urandom_range(0, PROG_WORDS - 1));
    op   = 4'($urandom);
    x    = 4'($urandom);
    y    = 4'($urandom);
    lo   = 8'($urandom);
    case (op)
      OP_SYS: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) return {OP_SYS, 4'h0, LO_CLS};
        if (pick < 6) return {OP_SYS, 4'h0, LO_RET};
        return {OP_SYS, x, lo};
      end
      OP_JP:   return {OP_JP, dest};
      OP_CALL: begin
        // calling itself piles up return addresses until the stack overflows
        if ($urandom_range(0, 2) == 0) return {OP_CALL, base + 12'(2 * idx)};
        return {OP_CALL, dest};
      end
      OP_JPV0: begin
        if ($urandom_range(0, 5) == 0) return {OP_JPV0, 12'($urandom)};
        return {OP_JPV0, dest - 12'($urandom_range(0, 8))};
      end
      OP_SNER: return {OP_SNER, x, y, ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h0};
      OP_KEY: begin
        pick = $urandom_range(0, 4);
        return {OP_KEY, x, (pick < 2) ? LO_SKP : (pick < 4) ? LO_SKNP : lo};
      end
      OP_MISC: begin
        case ($urandom_range(0, 10))
          0:  return {OP_MISC, x, LO_GDT};
          1:  return {OP_MISC, x, LO_WKEY};
          2:  return {OP_MISC, x, LO_SDT};
          3:  return {OP_MISC, x, LO_SST};
          4:  return {OP_MISC, x, LO_ADDX};
          5:  return {OP_MISC, x, LO_FONT};
          6:  return {OP_MISC, x, LO_BCD};
          7:  return {OP_MISC, x, LO_STR};
          8:  return {OP_MISC, x, LO_LDR};
          default: return {OP_MISC, x, lo};
        endcase
      end
      default: return {op, x, lo};
    endcase
  endfunction

  task automatic run_program(logic [11:0] base, int steps);
    int pick;
    for (int i = 0; i < PROG_WORDS; i++)
      load_word(base + 12'(2 * i), make_instr(base, i));
    for (int j = 0; j < steps; j++) begin
      if ($urandom_range(0, 2) == 0) held_keys = 16'($urandom);
      pick = $urandom_range(0, 15);
      if (pick < 2)
        push_req(CMD_TICK, 12'($urandom), 8'($urandom), 16'($urandom));
      else if (pick < 4)
        push_req(CMD_READ, (pick == 2) ? 12'($urandom) : 12'($urandom_range(0, 255)),
                 8'($urandom), 16'($urandom));
      else if (pick == 4)
        push_req(CMD_WRITE, 12'($urandom), 8'($urandom), 16'($urandom));
      else
        push_req(CMD_EXEC, 12'($urandom), 8'($urandom), held_keys);
    end
    drain();
  endtask

  initial begin
    logic [15:0] boot [8];
    logic [11:0] start;
    logic [15:0] seed;
    boot = '{{OP_SYS, 4'h0, LO_RET}, {OP_LDI, 4'hA, 8'h3D}, {OP_LDI, 4'hB, 8'h1F},
             {OP_DRW, 4'hA, 4'hB, 4'h5}, {OP_MISC, 4'h0, LO_WKEY},
             {OP_MISC, 4'h0, LO_WKEY}, {OP_LDI, 4'h0, 8'hFF}, {OP_JPV0, 12'hFFF}};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: underflow, wrapped draw, key wait
    set_config(12'd512, 16'hACE1);
    push_req(CMD_READ, 12'd0, 8'h00, 16'h0000);
    push_req(CMD_READ, 12'hFFF, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) load_word(12'd512 + 12'(2 * i), boot[i]);
    for (int j = 0; j < 9; j++)
      push_req(CMD_EXEC, 12'h000, 8'h00, (j == 4) ? 16'h0001 : 16'h0000);
    push_req(CMD_TICK, 12'h000, 8'h00, 16'h0000);
    push_req(CMD_READ, 12'd255, 8'h00, 16'h0000);
    drain();

    for (int p = 0; p < 11; p++) begin
      calm  = (p >= 9);
      start = (p == 0) ? 12'd0 : (p == 1) ? 12'hFFF : (p == 2) ? 12'hFFE :
              12'($urandom_range(0, 4000));
      seed  = (p == 0) ? 16'd1 : (p == 1) ? 16'hFFFF : (p == 2) ? 16'd0 : 16'($urandom);
      set_config(start, seed);
      if (p == 3) long_hold = 1;
      run_program(start, 79);
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/c8_pkg.sv
rtl/c8_if.sv
rtl/c8_ram.sv
rtl/c8_alu.sv
rtl/chip8_core_execute_unit.sv
dv/chip8_core_execute_checker.sv
dv/chip8_core_execute_unit_test.sv
